FILE: rtl/lag_pkg.sv
// lag_pkg: shared constants for the langton ant grid engine
// no dependencies; imported by langton_ant_grid_engine
`default_nettype none
package lag_pkg;

	localparam int GridWidthDef  = 64;
	localparam int GridHeightDef = 64;

	localparam int StepW   = 9;
	localparam int SampleW = 6;
	localparam int PosOutW = 6;
	localparam int TotalW  = 32;
	localparam int BlockW  = 3;

	localparam int InDataW  = 24;
	localparam int OutDataW = 56;

	typedef enum logic [1:0] {
		HEAD_NORTH = 2'd0,
		HEAD_EAST  = 2'd1,
		HEAD_SOUTH = 2'd2,
		HEAD_WEST  = 2'd3
	} heading_t;

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_REDUCE  = 7'b0000100,
		ST_SAMPLE  = 7'b0001000,
		ST_STEP_RD = 7'b0010000,
		ST_STEP_WR = 7'b0100000,
		ST_FINISH  = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/lag_ram.sv
// lag_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module lag_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/langton_ant_grid_engine.sv
// langton_ant_grid_engine: toroidal one-bit grid walked by a langton ant
// depends on lag_pkg and lag_ram
//
// usage:
// one input stream (in_*) carries requests: in_tuser is the request kind
// (0 advance, 1 sample), in_tdata holds step count and sample corner.
// one output stream (out_*) returns exactly one result per request.
// an advance does each ant step as a grid read (ST_STEP_RD), then a
// flip-write and move (ST_STEP_WR), and ends in ST_FINISH.
// a sample reads the four grid cells of its block after coordinate wrap;
// the wrap subtracts one grid size per cycle.
// the grid ram has one write port and one read port.
// after reset the grid is cleared one cell per cycle, all GRID_WIDTH *
// GRID_HEIGHT cells, with in_tready low.
// the result sits in an output register; a new request is taken while it
// waits, and the engine holds a finished result until out_tready frees it.
`default_nettype none
module langton_ant_grid_engine
	import lag_pkg::*;
#(
	parameter int GRID_WIDTH  = GridWidthDef,
	parameter int GRID_HEIGHT = GridHeightDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_tvalid,
	output logic                     in_tready,
	// step_count[8:0], sample_col[14:9], sample_row[20:15], zero pad
	input  wire logic [InDataW-1:0]  in_tdata,
	// req_type[0]
	input  wire logic                in_tuser,
	output logic                     out_tvalid,
	input  wire logic                out_tready,
	// ant_col[5:0], ant_row[11:6], ant_heading[13:12], total_steps[45:14],
	// block_count[48:46], ant_near[49], zero pad
	output logic      [OutDataW-1:0] out_tdata
);

	localparam int CW    = $clog2(GRID_WIDTH);
	localparam int RW    = $clog2(GRID_HEIGHT);
	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMPW  = ((SampleW > CW) ? SampleW : CW) + 1;
	localparam int HMAXW = ((SampleW > RW) ? SampleW : RW) + 1;

	state_t state_q;

	logic [CW-1:0]     ant_x_q;
	logic [RW-1:0]     ant_y_q;
	logic [1:0]        ant_dir_q;
	logic [TotalW-1:0] step_total_q;
	logic [StepW-1:0]  rem_q;
	logic [CMPW-1:0]   samp_c_q;
	logic [HMAXW-1:0]  samp_r_q;
	logic [2:0]        samp_idx_q;
	logic [BlockW-1:0] block_q;
	logic              near_q;
	logic [AW-1:0]     clr_addr_q;

	logic              out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;

	logic [CW-1:0] c0, c1, rd_col;
	logic [RW-1:0] r0, r1, rd_row;
	logic [AW-1:0] ant_addr;
	logic [AW-1:0] samp_addr;
	logic          c_big, r_big;
	logic [1:0]    new_dir;
	logic          out_free;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
	                                            input logic [RW-1:0] row);
		cell_addr = AW'(AW'(row) * AW'(GRID_WIDTH)) + AW'(col);
	endfunction

	assign c0 = CW'(samp_c_q);
	assign r0 = RW'(samp_r_q);
	assign c1 = (c0 == CW'(GRID_WIDTH - 1)) ? '0 : c0 + CW'(1);
	assign r1 = (r0 == RW'(GRID_HEIGHT - 1)) ? '0 : r0 + RW'(1);
	assign c_big = samp_c_q >= CMPW'(GRID_WIDTH);
	assign r_big = samp_r_q >= HMAXW'(GRID_HEIGHT);

	assign rd_col    = samp_idx_q[0] ? c1 : c0;
	assign rd_row    = samp_idx_q[1] ? r1 : r0;
	assign samp_addr = cell_addr(rd_col, rd_row);
	assign ant_addr  = cell_addr(ant_x_q, ant_y_q);

	assign new_dir   = ram_rdata ? ant_dir_q + 2'd3 : ant_dir_q + 2'd1;
	assign in_tready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_tready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ant_addr;
		ram_wdata = 1'b0;
		ram_raddr = ant_addr;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
			end
			ST_SAMPLE: begin
				ram_raddr = samp_addr;
			end
			ST_STEP_WR: begin
				ram_we    = 1'b1;
				ram_wdata = !ram_rdata;
			end
			default: begin
				ram_raddr = ant_addr;
			end
		endcase
	end

	lag_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			ant_x_q      <= CW'(GRID_WIDTH / 2);
			ant_y_q      <= RW'(GRID_HEIGHT / 2);
			ant_dir_q    <= HEAD_EAST;
			step_total_q <= '0;
			rem_q        <= '0;
			samp_c_q     <= '0;
			samp_r_q     <= '0;
			samp_idx_q   <= '0;
			block_q      <= '0;
			near_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_tvalid) begin
						block_q    <= '0;
						near_q     <= 1'b0;
						samp_idx_q <= '0;
						samp_c_q   <= CMPW'(in_tdata[StepW +: SampleW]);
						samp_r_q   <= HMAXW'(in_tdata[StepW + SampleW +: SampleW]);
						rem_q      <= in_tdata[StepW-1:0];
						if (in_tuser) begin
							state_q <= ST_REDUCE;
						end else begin
							step_total_q <= step_total_q + TotalW'(in_tdata[StepW-1:0]);
							state_q <= (in_tdata[StepW-1:0] == '0) ? ST_FINISH : ST_STEP_RD;
						end
					end
				end
				ST_REDUCE: begin
					if (c_big) begin
						samp_c_q <= samp_c_q - CMPW'(GRID_WIDTH);
					end
					if (r_big) begin
						samp_r_q <= samp_r_q - HMAXW'(GRID_HEIGHT);
					end
					if (!c_big && !r_big) begin
						state_q <= ST_SAMPLE;
						near_q  <= ((c0 == ant_x_q) && (r0 == ant_y_q)) ||
						           ((c1 == ant_x_q) && (r0 == ant_y_q)) ||
						           ((c0 == ant_x_q) && (r1 == ant_y_q));
					end
				end
				ST_SAMPLE: begin
					samp_idx_q <= samp_idx_q + 3'd1;
					if (samp_idx_q != 3'd0) begin
						block_q <= block_q + BlockW'(ram_rdata);
					end
					if (samp_idx_q == 3'd4) begin
						state_q <= ST_FINISH;
					end
				end
				ST_STEP_RD: begin
					state_q <= ST_STEP_WR;
				end
				ST_STEP_WR: begin
					ant_dir_q <= new_dir;
					case (new_dir)
						HEAD_NORTH: begin
							ant_y_q <= (ant_y_q == '0) ? RW'(GRID_HEIGHT - 1)
							                           : ant_y_q - RW'(1);
						end
						HEAD_EAST: begin
							ant_x_q <= (ant_x_q == CW'(GRID_WIDTH - 1)) ? '0
							                                          : ant_x_q + CW'(1);
						end
						HEAD_SOUTH: begin
							ant_y_q <= (ant_y_q == RW'(GRID_HEIGHT - 1)) ? '0
							                                           : ant_y_q + RW'(1);
						end
						default: begin
							ant_x_q <= (ant_x_q == '0) ? CW'(GRID_WIDTH - 1)
							                           : ant_x_q - CW'(1);
						end
					endcase
					rem_q   <= rem_q - StepW'(1);
					state_q <= (rem_q == StepW'(1)) ? ST_FINISH : ST_STEP_RD;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_data_q <= {6'd0, near_q, block_q, step_total_q, ant_dir_q,
			               PosOutW'(ant_y_q), PosOutW'(ant_x_q)};
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;

endmodule
`default_nettype wire
